// ===== rtl/scheduler_clock_tick_engine_defines.svh =====
// Assertion macros for the tick engine RTL.
// Clocked on aclk, disabled while aresetn is low; NO_ASSERTIONS removes them.
`ifndef SCHEDULER_CLOCK_TICK_ENGINE_DEFINES_SVH
`define SCHEDULER_CLOCK_TICK_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCTK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tick engine assertion failed");
`define SCTK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tick engine assertion failed");
`else
`define SCTK_ASSERT(lbl, prop)
`define SCTK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/sctk_pkg.sv =====
// Shared types and constants of the scheduler clock tick engine.
// No dependencies.
`default_nettype none
package sctk_pkg;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  proc_index;
        logic        base_priority;
        logic        user_mode;
        logic        pc_at_idle;
        logic [2:0]  disk_busy;
        logic        swapper_waiting;
        logic        entry_live;
        logic [5:0]  entry_nice;
        logic [15:0] entry_alarm;
        logic [6:0]  entry_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  entry_index;
        logic [4:0]  hist_slot;
        logic [31:0] hist_count;
        logic [31:0] mode_ticks;
        logic [31:0] seconds;
        logic [7:0]  cpu_usage;
        logic [6:0]  run_time;
        logic        alarm_fired;
        logic        recompute_priority;
        logic        wake_swapper;
        logic        done_res;
    } res_t;

    // One process table entry
    typedef struct packed {
        logic [5:0]  nice;
        logic [15:0] alarm;
        logic [6:0]  prio;
        logic [7:0]  usage;
        logic [6:0]  run_time;
    } rec_t;

    typedef struct packed {
        logic [31:0] user_ticks;
        logic [31:0] system_ticks;
    } ticks_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_entry;
        logic tick_cap;
        logic tick_chg;
        logic tick_fin;
        logic sw_sel;
        logic sw_skip;
        logic sw_upd;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_is_write;
        logic second;
        logic sweep_end;
        logic sweep_live;
    } status_t;

    localparam logic       REQ_WRITE      = 1'b1;
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_SECOND    = 2'd1;
    localparam logic [1:0] KIND_UPDATE    = 2'd2;
    localparam logic [1:0] CFG_TPS        = 2'd0;
    localparam logic [1:0] CFG_NICE_ZERO  = 2'd1;
    localparam logic [1:0] CFG_PRIO_FLOOR = 2'd2;
    localparam logic [9:0] TPS_RESET      = 10'd60;
    localparam logic [5:0] NICE_ZERO_RESET = 6'd20;
    localparam logic [6:0] FLOOR_RESET    = 7'd50;
    localparam logic [5:0] MAX_UPDATES    = 6'd32;
    localparam logic [7:0] USAGE_MAX      = 8'd255;
    localparam logic [6:0] RUN_TIME_MAX   = 7'd127;
    localparam logic [15:0] TICK_COUNT_MAX = 16'hFFFF;
    localparam int         HIST_SLOTS     = 32;

endpackage
`default_nettype wire

// ===== rtl/scheduler_clock_tick_engine.sv =====
// Scheduler clock tick engine. A write gives no result; a tick reads the table at
// acceptance, then charges (T_CHG) and updates the histogram and result (T_HIST).
// A tick that completes a second then walks the process slots, skipping idle ones
// and updating live ones, until the last slot or MAX_UPDATES updates.
// One item is in work at a time. Reset (aresetn low, synchronous) clears counters,
// histogram and table state through valid bits, and loads the register defaults.
`default_nettype none
module scheduler_clock_tick_engine #(
    parameter int PROCESS_SLOTS = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire sctk_pkg::req_t s_req,
    output logic                m_valid,
    input  wire logic           m_ready,
    output sctk_pkg::res_t      m_res,
    input  wire logic           cfg_wr_en,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [9:0]     cfg_wdata
);
    sctk_pkg::cmd_t    cmd;
    sctk_pkg::status_t status;

    sctk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sctk_dp #(.PROCESS_SLOTS(PROCESS_SLOTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_req     (s_req),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_res     (m_res)
    );
endmodule
`default_nettype wire

// ===== rtl/sctk_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module sctk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/sctk_ctrl.sv =====
// Controller of the tick engine: sequences ticks, writes and the per-second sweep.
// Depends on sctk_pkg and the assertion macro header.
`default_nettype none
`include "scheduler_clock_tick_engine_defines.svh"
module sctk_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire sctk_pkg::status_t status,
    output sctk_pkg::cmd_t         cmd
);
    typedef enum logic [2:0] {IDLE, T_CHG, T_HIST, SW_CHK, SW_UPD} state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free, load;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = m_valid_reg;

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    if (status.req_is_write) begin
                        cmd.wr_entry = 1'b1;
                    end else begin
                        cmd.tick_cap = 1'b1;
                        state_next   = T_CHG;
                    end
                end
            end
            T_CHG: begin
                cmd.tick_chg = 1'b1;
                state_next   = T_HIST;
            end
            T_HIST: begin
                if (out_free) begin
                    cmd.tick_fin = 1'b1;
                    state_next   = status.second ? SW_CHK : IDLE;
                end
            end
            SW_CHK: begin
                cmd.sw_sel = 1'b1;
                if (status.sweep_end) begin
                    state_next = IDLE;
                end else if (!status.sweep_live) begin
                    cmd.sw_skip = 1'b1;
                end else begin
                    state_next = SW_UPD;
                end
            end
            SW_UPD: begin
                cmd.sw_sel = 1'b1;
                if (out_free) begin
                    cmd.sw_upd = 1'b1;
                    state_next = SW_CHK;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    assign load         = cmd.tick_fin || cmd.sw_upd;
    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Hold state and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `SCTK_ASSERT(a_load_free, !load || out_free)
    `SCTK_ASSERT_NEXT(a_chg_to_hist, state_reg == T_CHG, state_reg == T_HIST)
    `SCTK_ASSERT_NEXT(a_upd_waits, state_reg == SW_UPD && !out_free, state_reg == SW_UPD)
    `SCTK_ASSERT_NEXT(a_result_held, m_valid_reg && !m_ready, m_valid_reg)
endmodule
`default_nettype wire

// ===== rtl/sctk_dp.sv =====
// Datapath of the tick engine: config, counters, process table, histogram, result register.
// Depends on sctk_pkg and sctk_ram.
`default_nettype none
module sctk_dp #(
    parameter int PROCESS_SLOTS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sctk_pkg::req_t    s_req,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [9:0]        cfg_wdata,
    input  wire sctk_pkg::cmd_t    cmd,
    output sctk_pkg::status_t      status,
    output sctk_pkg::res_t         m_res
);
    localparam int AW = $clog2(PROCESS_SLOTS);
    localparam int CW = $clog2(PROCESS_SLOTS + 1);

    logic [9:0]  tps_reg;
    logic [5:0]  nz_reg;
    logic [6:0]  floor_reg;
    logic [15:0] tick_count_reg;
    logic [31:0] seconds_reg;
    sctk_pkg::req_t req_reg;
    logic [PROCESS_SLOTS-1:0] live_reg, rec_valid_reg, ticks_valid_reg;
    logic [sctk_pkg::HIST_SLOTS-1:0] hist_valid_reg;
    logic [4:0]  slot_reg;
    logic [31:0] mt_reg;
    logic [7:0]  usage_reg;
    logic [6:0]  rt_reg;
    logic [CW-1:0] sw_idx_reg;
    logic [5:0]  upd_cnt_reg;
    sctk_pkg::res_t out_reg;

    logic [5:0]    s_idx_ext, r_idx_ext, sw_idx_ext;
    logic          s_in_range, r_in_range;
    logic [AW-1:0] s_addr, r_addr, sw_addr, rd_addr, rec_wr_addr;
    sctk_pkg::rec_t   rec_rd, rec_wr;
    sctk_pkg::ticks_t ticks_rd, ticks_wr;
    logic          rec_wr_en;
    logic [31:0]   hist_rd, hist_new;
    logic [4:0]    hist_rd_addr;

    // Index handling
    assign s_idx_ext  = {1'b0, s_req.proc_index};
    assign r_idx_ext  = {1'b0, req_reg.proc_index};
    assign sw_idx_ext = 6'(sw_idx_reg);
    assign s_in_range = s_idx_ext < 6'(PROCESS_SLOTS);
    assign r_in_range = r_idx_ext < 6'(PROCESS_SLOTS);
    assign s_addr     = s_idx_ext[AW-1:0];
    assign r_addr     = r_idx_ext[AW-1:0];
    assign sw_addr    = sw_idx_reg[AW-1:0];
    assign rd_addr    = cmd.sw_sel ? sw_addr : s_addr;

    // Tick charge: slot, mode ticks, usage
    logic [7:0]  old_usage;
    logic [6:0]  old_rt;
    logic        nice_gt;
    logic [4:0]  slot_next;
    logic [31:0] user_t, sys_t, mt_next;
    logic [7:0]  usage_next;

    always_comb begin
        old_usage = rec_valid_reg[r_addr] ? rec_rd.usage : 8'd0;
        old_rt    = rec_valid_reg[r_addr] ? rec_rd.run_time : 7'd0;
        nice_gt   = r_in_range && (rec_rd.nice > nz_reg);
        if (req_reg.user_mode) begin
            slot_next = {2'b00, req_reg.disk_busy} + (nice_gt ? 5'd8 : 5'd0);
        end else begin
            slot_next = {2'b00, req_reg.disk_busy} + 5'd16
                        + (req_reg.pc_at_idle ? 5'd8 : 5'd0);
        end
        user_t = ticks_valid_reg[r_addr] ? ticks_rd.user_ticks : 32'd0;
        sys_t  = ticks_valid_reg[r_addr] ? ticks_rd.system_ticks : 32'd0;
        if (req_reg.user_mode) begin
            user_t = user_t + 32'd1;
        end else begin
            sys_t = sys_t + 32'd1;
        end
        mt_next  = req_reg.user_mode ? user_t : sys_t;
        ticks_wr = '{user_ticks: user_t, system_ticks: sys_t};
        usage_next = (old_usage == sctk_pkg::USAGE_MAX) ? old_usage : old_usage + 8'd1;
    end

    // Tick finish: histogram, tick count, second decision
    logic [15:0] tc_inc;
    logic        second;
    logic [31:0] seconds_next;
    logic        any_live;

    assign hist_new     = (hist_valid_reg[slot_reg] ? hist_rd : 32'd0) + 32'd1;
    assign tc_inc       = (tick_count_reg == sctk_pkg::TICK_COUNT_MAX) ?
                          tick_count_reg : tick_count_reg + 16'd1;
    assign second       = ({6'd0, tps_reg} <= tc_inc) && !req_reg.base_priority;
    assign seconds_next = seconds_reg + 32'd1;
    assign any_live     = |live_reg;
    assign hist_rd_addr = cmd.tick_chg ? slot_next : slot_reg;

    // Sweep: age one entry
    logic [6:0]  rt_new;
    logic [15:0] alarm_new;
    logic        fired;
    logic [9:0]  x4;
    logic [17:0] prod;
    logic signed [10:0] decay;
    logic [7:0]  usage_dec;
    logic        live_after;
    logic        done_upd;

    always_comb begin
        rt_new    = (rec_rd.run_time == sctk_pkg::RUN_TIME_MAX) ?
                    rec_rd.run_time : rec_rd.run_time + 7'd1;
        alarm_new = rec_rd.alarm;
        fired     = 1'b0;
        if (rec_rd.alarm != 16'd0) begin
            alarm_new = rec_rd.alarm - 16'd1;
            fired     = (rec_rd.alarm == 16'd1);
        end
        // usage*8/10 = (usage*4)/5, divide by 5 as multiply by 205 and shift by 10
        x4    = {rec_rd.usage, 2'b00};
        prod  = 18'(x4) * 18'd205;
        decay = $signed({3'b000, prod[17:10]}) + $signed({5'b00000, rec_rd.nice})
                - $signed({5'b00000, nz_reg});
        if (decay < 0) begin
            usage_dec = 8'd0;
        end else if (decay > 11'sd255) begin
            usage_dec = 8'd255;
        end else begin
            usage_dec = decay[7:0];
        end
        live_after = 1'b0;
        for (int j = 0; j < PROCESS_SLOTS; j++) begin
            if (CW'(j) > sw_idx_reg) begin
                live_after = live_after | live_reg[j];
            end
        end
        done_upd = (upd_cnt_reg == sctk_pkg::MAX_UPDATES - 6'd1) || !live_after;
    end

    // Process table write selection
    always_comb begin
        rec_wr_en   = 1'b0;
        rec_wr_addr = s_addr;
        rec_wr      = rec_rd;
        if (cmd.wr_entry) begin
            rec_wr_en = s_in_range;
            rec_wr    = '{nice: s_req.entry_nice, alarm: s_req.entry_alarm,
                          prio: s_req.entry_priority, usage: 8'd0, run_time: 7'd0};
        end else if (cmd.tick_chg) begin
            rec_wr_en      = r_in_range;
            rec_wr_addr    = r_addr;
            rec_wr.usage    = usage_next;
            rec_wr.run_time = old_rt;
        end else if (cmd.sw_upd) begin
            rec_wr_en       = 1'b1;
            rec_wr_addr     = sw_addr;
            rec_wr.alarm    = alarm_new;
            rec_wr.usage    = usage_dec;
            rec_wr.run_time = rt_new;
        end
    end

    sctk_ram #(.WIDTH($bits(sctk_pkg::rec_t)), .DEPTH(PROCESS_SLOTS)) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_data (rec_wr),
        .rd_addr (rd_addr),
        .rd_data (rec_rd)
    );

    sctk_ram #(.WIDTH($bits(sctk_pkg::ticks_t)), .DEPTH(PROCESS_SLOTS)) u_ticks_ram (
        .aclk    (aclk),
        .wr_en   (cmd.tick_chg && r_in_range),
        .wr_addr (r_addr),
        .wr_data (ticks_wr),
        .rd_addr (rd_addr),
        .rd_data (ticks_rd)
    );

    sctk_ram #(.WIDTH(32), .DEPTH(sctk_pkg::HIST_SLOTS)) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (cmd.tick_fin),
        .wr_addr (slot_reg),
        .wr_data (hist_new),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd)
    );

    // Control registers: config, counters, valid bits, sweep position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg         <= sctk_pkg::TPS_RESET;
            nz_reg          <= sctk_pkg::NICE_ZERO_RESET;
            floor_reg       <= sctk_pkg::FLOOR_RESET;
            tick_count_reg  <= '0;
            seconds_reg     <= '0;
            live_reg        <= '0;
            rec_valid_reg   <= '0;
            ticks_valid_reg <= '0;
            hist_valid_reg  <= '0;
            sw_idx_reg      <= '0;
            upd_cnt_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    sctk_pkg::CFG_TPS:        tps_reg   <= cfg_wdata;
                    sctk_pkg::CFG_NICE_ZERO:  nz_reg    <= cfg_wdata[5:0];
                    sctk_pkg::CFG_PRIO_FLOOR: floor_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (cmd.wr_entry && s_in_range) begin
                live_reg[s_addr]      <= s_req.entry_live;
                rec_valid_reg[s_addr] <= 1'b1;
            end
            if (cmd.tick_chg && r_in_range) begin
                rec_valid_reg[r_addr]   <= 1'b1;
                ticks_valid_reg[r_addr] <= 1'b1;
            end
            if (cmd.tick_fin) begin
                hist_valid_reg[slot_reg] <= 1'b1;
                tick_count_reg <= second ? tc_inc - {6'd0, tps_reg} : tc_inc;
                if (second) begin
                    seconds_reg <= seconds_next;
                end
                sw_idx_reg  <= '0;
                upd_cnt_reg <= '0;
            end
            if (cmd.sw_skip || cmd.sw_upd) begin
                sw_idx_reg <= sw_idx_reg + CW'(1);
            end
            if (cmd.sw_upd) begin
                upd_cnt_reg <= upd_cnt_reg + 6'd1;
            end
        end
    end

    // Payload registers: captured request, tick charge, result
    always_ff @(posedge aclk) begin
        if (cmd.tick_cap) begin
            req_reg <= s_req;
        end
        if (cmd.tick_chg) begin
            slot_reg  <= slot_next;
            mt_reg    <= r_in_range ? mt_next : 32'd0;
            usage_reg <= r_in_range ? usage_next : 8'd0;
            rt_reg    <= r_in_range ? old_rt : 7'd0;
        end
        if (cmd.tick_fin) begin
            out_reg <= '{kind: second ? sctk_pkg::KIND_SECOND : sctk_pkg::KIND_TICK,
                         entry_index: req_reg.proc_index, hist_slot: slot_reg,
                         hist_count: hist_new, mode_ticks: mt_reg,
                         seconds: second ? seconds_next : seconds_reg,
                         cpu_usage: usage_reg, run_time: rt_reg,
                         alarm_fired: 1'b0, recompute_priority: 1'b0,
                         wake_swapper: second && req_reg.swapper_waiting,
                         done_res: second ? !any_live : 1'b1};
        end else if (cmd.sw_upd) begin
            out_reg <= '{kind: sctk_pkg::KIND_UPDATE, entry_index: sw_idx_ext[4:0],
                         hist_slot: 5'd0, hist_count: 32'd0, mode_ticks: 32'd0,
                         seconds: seconds_reg, cpu_usage: usage_dec, run_time: rt_new,
                         alarm_fired: fired,
                         recompute_priority: rec_rd.prio >= floor_reg,
                         wake_swapper: 1'b0, done_res: done_upd};
        end
    end

    assign status.req_is_write = (s_req.req_type == sctk_pkg::REQ_WRITE);
    assign status.second       = second;
    assign status.sweep_end    = (sw_idx_reg == CW'(PROCESS_SLOTS))
                                 || (upd_cnt_reg == sctk_pkg::MAX_UPDATES);
    assign status.sweep_live   = live_reg[sw_addr];
    assign m_res               = out_reg;
endmodule
`default_nettype wire

// ===== tb/scheduler_clock_tick_engine_tb.sv =====
// Self-checking testbench for the scheduler clock tick engine.
// Depends on sctk_pkg and scheduler_clock_tick_engine; predicts every result in-line.
`timescale 1ns / 100ps
module scheduler_clock_tick_engine_tb;

    localparam int SLOTS = 32;
    localparam int DRAIN_CYCLES = 80;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    sctk_pkg::req_t s_req = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    sctk_pkg::res_t m_res;
    logic           cfg_wr_en = 1'b0;
    logic [1:0]     cfg_index = '0;
    logic [9:0]     cfg_wdata = '0;

    // Pending tick results, oldest first
    sctk_pkg::res_t pending_res[$];
    int   mismatches = 0;
    bit   quiet = 1'b0;

    // Shadow copy of the block's registers and state
    bit [9:0]  tps_q;
    bit [5:0]  nice_zero_q;
    bit [6:0]  prio_floor_q;
    bit [15:0] tick_cnt;
    bit [31:0] sec_cnt;
    bit [31:0] hist[sctk_pkg::HIST_SLOTS];
    bit        live[SLOTS];
    bit [5:0]  nice[SLOTS];
    bit [15:0] alarm[SLOTS];
    bit [6:0]  prio[SLOTS];
    bit [7:0]  usage[SLOTS];
    bit [6:0]  run_time[SLOTS];
    bit [31:0] user_ticks[SLOTS];
    bit [31:0] sys_ticks[SLOTS];

    scheduler_clock_tick_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_res(m_res),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Apply one accepted request to the shadow state and queue its results
    task automatic charge_tick(input sctk_pkg::req_t r);
        sctk_pkg::res_t t;
        bit [4:0]  slot;
        bit [31:0] mt;
        int        a;
        int        i;
        if (r.req_type == sctk_pkg::REQ_WRITE) begin
            live[r.proc_index]     = r.entry_live;
            nice[r.proc_index]     = r.entry_nice;
            alarm[r.proc_index]    = r.entry_alarm;
            prio[r.proc_index]     = r.entry_priority;
            usage[r.proc_index]    = '0;
            run_time[r.proc_index] = '0;
            return;
        end
        slot = {2'b00, r.disk_busy};
        if (r.user_mode) begin
            user_ticks[r.proc_index]++;
            mt = user_ticks[r.proc_index];
            if (nice[r.proc_index] > nice_zero_q) slot += 5'd8;
        end else begin
            slot += 5'd16;
            if (r.pc_at_idle) slot += 5'd8;
            sys_ticks[r.proc_index]++;
            mt = sys_ticks[r.proc_index];
        end
        hist[slot]++;
        if (usage[r.proc_index] != sctk_pkg::USAGE_MAX) usage[r.proc_index]++;
        if (tick_cnt != sctk_pkg::TICK_COUNT_MAX) tick_cnt++;
        t = '0;
        t.entry_index = r.proc_index;
        t.hist_slot   = slot;
        t.hist_count  = hist[slot];
        t.mode_ticks  = mt;
        t.cpu_usage   = usage[r.proc_index];
        t.run_time    = run_time[r.proc_index];
        if (tick_cnt >= tps_q && !r.base_priority) begin
            tick_cnt -= tps_q;
            sec_cnt++;
            t.kind         = sctk_pkg::KIND_SECOND;
            t.seconds      = sec_cnt;
            t.wake_swapper = r.swapper_waiting;
            pending_res.push_back(t);
            // Age every live entry
            for (i = 0; i < SLOTS; i++) begin
                if (!live[i]) continue;
                t = '0;
                t.kind = sctk_pkg::KIND_UPDATE;
                t.entry_index = i[4:0];
                t.seconds = sec_cnt;
                if (run_time[i] != sctk_pkg::RUN_TIME_MAX) run_time[i]++;
                if (alarm[i] != 0) begin
                    alarm[i]--;
                    t.alarm_fired = (alarm[i] == 0);
                end
                a = int'(usage[i]) * 8 / 10 + int'(nice[i]) - int'(nice_zero_q);
                if (a < 0) a = 0;
                if (a > 255) a = 255;
                usage[i] = a[7:0];
                t.cpu_usage = usage[i];
                t.run_time = run_time[i];
                t.recompute_priority = (prio[i] >= prio_floor_q);
                pending_res.push_back(t);
            end
        end else begin
            t.kind    = sctk_pkg::KIND_TICK;
            t.seconds = sec_cnt;
            pending_res.push_back(t);
        end
        // Mark the last result of this tick
        t = pending_res.pop_back();
        t.done_res = 1'b1;
        pending_res.push_back(t);
    endtask

    // Send one request; entered and left at a falling edge
    task automatic send_request(input sctk_pkg::req_t r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req   <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        charge_tick(r);
        @(negedge aclk);
    endtask

    // Drop valid, wait for all results and let the block finish its sweep
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            sctk_pkg::CFG_TPS:        tps_q = val;
            sctk_pkg::CFG_NICE_ZERO:  nice_zero_q = val[5:0];
            sctk_pkg::CFG_PRIO_FLOOR: prio_floor_q = val[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic sctk_pkg::req_t entry_write(input int idx, input int lv, input int nc,
                                                   input int al, input int pr);
        sctk_pkg::req_t r;
        r = '0;
        r.req_type = sctk_pkg::REQ_WRITE;
        r.proc_index = idx[4:0];
        r.entry_live = lv[0];
        r.entry_nice = nc[5:0];
        r.entry_alarm = al[15:0];
        r.entry_priority = pr[6:0];
        return r;
    endfunction

    function automatic sctk_pkg::req_t tick_req(input int idx, input int raised, input int usr,
                                                input int idle, input int disk, input int swap);
        sctk_pkg::req_t r;
        r = '0;
        r.req_type = ~sctk_pkg::REQ_WRITE;
        r.proc_index = idx[4:0];
        r.base_priority = raised[0];
        r.user_mode = usr[0];
        r.pc_at_idle = idle[0];
        r.disk_busy = disk[2:0];
        r.swapper_waiting = swap[0];
        // Junk in the write-only fields
        r.entry_live = 1'($urandom());
        r.entry_nice = 6'($urandom());
        r.entry_alarm = 16'($urandom());
        r.entry_priority = 7'($urandom());
        return r;
    endfunction

    function automatic sctk_pkg::req_t random_req();
        if ($urandom_range(0, 9) < 3)
            return entry_write($urandom_range(0, 31), int'($urandom_range(0, 9) < 7),
                               $urandom_range(0, 63),
                               ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 65535),
                               $urandom_range(0, 127));
        return tick_req($urandom_range(0, 31), int'($urandom_range(0, 3) == 0),
                        $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 7), $urandom_range(0, 1));
    endfunction

    // Load every entry, with the extremes of each field
    task automatic test_entry_writes();
        int i;
        send_request(entry_write(0, 1, 0, 0, 0));
        send_request(entry_write(1, 1, 63, 1, 127));
        send_request(entry_write(2, 1, 39, 65535, 50));
        send_request(entry_write(3, 0, 20, 2, 49));
        for (i = 4; i < SLOTS; i++)
            send_request(entry_write(i, int'(i % 3 != 0), $urandom_range(0, 63),
                                     $urandom_range(0, 4), $urandom_range(0, 127)));
    endtask

    // Every histogram path, swapper wakeup and raised priority at the boundary
    task automatic test_tick_paths();
        int i;
        settle();
        write_reg(sctk_pkg::CFG_TPS, 10'd3);
        send_request(tick_req(1, 0, 1, 0, 7, 1));
        send_request(tick_req(0, 0, 1, 1, 0, 0));
        send_request(tick_req(2, 1, 0, 1, 5, 1));
        send_request(tick_req(3, 1, 0, 0, 2, 1));
        send_request(tick_req(31, 0, 0, 1, 7, 1));
        for (i = 0; i < 6; i++)
            send_request(tick_req(i, 0, i % 2, (i / 2) % 2, i, 1 - i % 2));
    endtask

    // Register extremes: zero and one ticks per second, nice and floor ends
    task automatic test_register_extremes();
        int i;
        settle();
        write_reg(sctk_pkg::CFG_TPS, 10'd0);
        write_reg(sctk_pkg::CFG_NICE_ZERO, 10'd0);
        write_reg(sctk_pkg::CFG_PRIO_FLOOR, 10'd0);
        // Enough seconds to saturate run time
        for (i = 0; i < 135; i++)
            send_request(tick_req(i % SLOTS, int'(i % 17 == 0), i % 2, (i / 4) % 2, i,
                                  (i / 2) % 2));
        settle();
        write_reg(sctk_pkg::CFG_TPS, 10'd1);
        write_reg(sctk_pkg::CFG_NICE_ZERO, 10'd63);
        write_reg(sctk_pkg::CFG_PRIO_FLOOR, 10'd127);
        for (i = 0; i < 6; i++)
            send_request(tick_req(1, 0, 1, 0, i, 1));
    endtask

    task automatic test_random_traffic();
        int i;
        for (i = 0; i < 75; i++) begin
            if (i % 65 == 0) begin
                settle();
                write_reg(sctk_pkg::CFG_TPS,
                          10'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6)));
                write_reg(sctk_pkg::CFG_NICE_ZERO, 10'($urandom_range(0, 63)));
                write_reg(sctk_pkg::CFG_PRIO_FLOOR, 10'($urandom_range(0, 127)));
            end
            if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            send_request(random_req());
        end
        quiet = 1'b0;
    endtask

    // Result side: random stall ahead of every result outside quiet phases
    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        sctk_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_res);
            end else begin
                want = pending_res.pop_front();
                if (m_res !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch\n  expected %p\n  actual   %p", want, m_res);
                end
            end
        end
    end

    initial begin : main_sequence
        tps_q = sctk_pkg::TPS_RESET;
        nice_zero_q = sctk_pkg::NICE_ZERO_RESET;
        prio_floor_q = sctk_pkg::FLOOR_RESET;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // A system tick before any entry is loaded
        send_request(tick_req(7, 0, 0, 0, 1, 0));
        test_entry_writes();
        test_tick_paths();
        test_register_extremes();
        test_random_traffic();
        settle();
        if (mismatches == 0 && pending_res.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
